FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while out of reset
`define LPHS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lphs assertion failed");

// Property checked at every edge, reset included
`define LPHS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lphs assertion failed");

`endif

FILE: rtl/core/lphs_pkg.sv
// Types and constants of the linear probe hash set
package lphs_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned MAX_SLOTS = 64;
  localparam logic [31:0] HASH_MUL = 32'h045D_9F3B;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_MAX      = 1'b1;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [CAP_W-1:0] home;
  } req_t;

endpackage

FILE: rtl/core/lphs_ram.sv
// Generic single write, single read RAM with registered read data
module lphs_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/core/lphs_front.sv
// Front end: accepts requests, hashes the key, reduces it to the home slot
module lphs_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_opcode,
  input  logic signed [31:0]      in_key,
  input  logic [lphs_pkg::CAP_W-1:0] cap,
  output logic                    push,
  output lphs_pkg::req_t          push_req,
  input  logic                    q_full
);
  import lphs_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MUL1, F_XOR2, F_MUL2, F_XOR3, F_DIV, F_PUSH} fstate_t;

  fstate_t           state_r;
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [31:0]       h_r;
  logic [CAP_W-1:0]  rem_r;
  logic [4:0]        cnt_r;
  logic [CAP_W:0]    trial;

  assign trial = {rem_r, h_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            key_r   <= in_key;
            h_r     <= (in_key >> 16) ^ in_key;
            state_r <= F_MUL1;
          end
        end
        F_MUL1: begin
          h_r     <= h_r * HASH_MUL;
          state_r <= F_XOR2;
        end
        F_XOR2: begin
          h_r     <= (h_r >> 16) ^ h_r;
          state_r <= F_MUL2;
        end
        F_MUL2: begin
          h_r     <= h_r * HASH_MUL;
          state_r <= F_XOR3;
        end
        F_XOR3: begin
          h_r     <= (h_r >> 16) ^ h_r;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= F_DIV;
        end
        F_DIV: begin
          // restoring remainder, one dividend bit per cycle
          if (trial >= {1'b0, cap}) begin
            rem_r <= CAP_W'(trial - {1'b0, cap});
          end else begin
            rem_r <= CAP_W'(trial);
          end
          h_r   <= {h_r[30:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != F_IDLE);
  assign push          = (state_r == F_PUSH) && !q_full;
  assign push_req.op   = op_r;
  assign push_req.key  = key_r;
  assign push_req.home = rem_r;
endmodule

FILE: rtl/core/lphs_fifo.sv
// Two entry request queue between front and back
module lphs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lphs_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output lphs_pkg::req_t pop_req,
  output logic           empty
);
  import lphs_pkg::*;

  req_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= push_req;
        wr_ptr_r      <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign pop_req = q_r[rd_ptr_r];
  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
endmodule

FILE: rtl/core/lphs_back.sv
// Back end: probes the table, applies the request and holds the result
module lphs_back #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  lphs_pkg::req_t             q_req,
  output logic                       pop,
  input  logic [lphs_pkg::CAP_W-1:0] cap,
  input  logic [lphs_pkg::CAP_W-1:0] max_entries,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [5:0]                 out_slot_index,
  output logic [6:0]                 out_stored_count
);
  import lphs_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned WW = KEY_W + 2;

  typedef enum logic [1:0] {B_IDLE, B_READ, B_EVAL, B_DONE} bstate_t;

  bstate_t          state_r;
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [CAP_W-1:0] pos_r;
  logic [CAP_W-1:0] n_r;
  logic             have_tomb_r;
  logic [CAP_W-1:0] tomb_r;
  logic             have_empty_r;
  logic [CAP_W-1:0] empty_r;
  logic             match_r;
  logic [CAP_W-1:0] match_pos_r;
  logic [CAP_W-1:0] count_r;
  logic [SLOTS-1:0] vld_r;
  logic             vld_q_r;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [5:0]       out_slot_r;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [WW-1:0]    wdata;
  logic [WW-1:0]    rdata;
  logic [1:0]       rd_mark;
  logic [KEY_W-1:0] rd_key;
  logic             slot_open;
  logic             slot_hit;
  logic             slot_tomb;
  logic [CAP_W-1:0] n_inc;
  logic [CAP_W-1:0] pos_inc;
  logic             done_go;

  // finish-time decision
  logic [2:0]       res_status;
  logic [CAP_W-1:0] res_slot;
  logic [CAP_W-1:0] res_count;
  logic [1:0]       res_mark;

  lphs_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pos_r[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_mark   = rdata[WW-1:KEY_W];
  assign rd_key    = rdata[KEY_W-1:0];
  // a slot never written reads as empty
  assign slot_open = !vld_q_r || (rd_mark == MARK_EMPTY);
  assign slot_hit  = vld_q_r && (rd_mark == MARK_USED) && (rd_key == key_r);
  assign slot_tomb = vld_q_r && (rd_mark == MARK_TOMB);
  assign n_inc     = n_r + 1'b1;
  assign pos_inc   = (pos_r + 1'b1 == cap) ? '0 : pos_r + 1'b1;
  assign done_go   = (state_r == B_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    res_status = ST_NOTFOUND;
    res_slot   = '0;
    res_count  = count_r;
    res_mark   = MARK_USED;
    we         = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (match_r) begin
          res_status = ST_PRESENT;
          res_slot   = match_pos_r;
        end else if (count_r >= max_entries || (!have_tomb_r && !have_empty_r)) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_INSERTED;
          res_slot   = have_tomb_r ? tomb_r : empty_r;
          res_count  = count_r + 1'b1;
          we         = done_go;
        end
      end
      OP_REMOVE: begin
        if (match_r) begin
          res_status = ST_REMOVED;
          res_slot   = match_pos_r;
          res_count  = count_r - 1'b1;
          res_mark   = MARK_TOMB;
          we         = done_go;
        end
      end
      OP_SEARCH: begin
        if (match_r) begin
          res_status = ST_FOUND;
          res_slot   = match_pos_r;
        end
      end
      default: ;
    endcase
  end

  assign waddr = res_slot[AW-1:0];
  assign wdata = {res_mark, key_r};
  assign pop   = (state_r == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      count_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            op_r         <= q_req.op;
            key_r        <= q_req.key;
            pos_r        <= q_req.home;
            n_r          <= '0;
            have_tomb_r  <= 1'b0;
            have_empty_r <= 1'b0;
            match_r      <= 1'b0;
            if (q_req.op == OP_NONE ||
                (q_req.op != OP_INSERT && count_r == '0)) begin
              state_r <= B_DONE;
            end else begin
              state_r <= B_READ;
            end
          end
        end
        B_READ: begin
          vld_q_r <= vld_r[pos_r[AW-1:0]];
          state_r <= B_EVAL;
        end
        B_EVAL: begin
          if (slot_open) begin
            have_empty_r <= 1'b1;
            empty_r      <= pos_r;
            state_r      <= B_DONE;
          end else if (slot_hit) begin
            match_r     <= 1'b1;
            match_pos_r <= pos_r;
            state_r     <= B_DONE;
          end else begin
            if (slot_tomb && !have_tomb_r) begin
              have_tomb_r <= 1'b1;
              tomb_r      <= pos_r;
            end
            n_r   <= n_inc;
            pos_r <= pos_inc;
            state_r <= (n_inc == cap) ? B_DONE : B_READ;
          end
        end
        B_DONE: begin
          if (done_go) begin
            out_status_r <= res_status;
            out_slot_r   <= 6'(res_slot);
            count_r      <= res_count;
            if (we) begin
              vld_r[res_slot[AW-1:0]] <= 1'b1;
            end
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_index   = out_slot_r;
  assign out_stored_count = count_r;
endmodule

FILE: rtl/core/linear_probe_hash_set_core.sv
// Linear probe hash set: a set of 32-bit keys in an open-addressed table.
// Input channel (in_valid/in_stall): opcode (0 insert, 1 remove, 2 search)
// and a signed key. Result channel (out_valid/out_stall): one result per
// request with status, matched or written slot index and the stored count.
// A transfer happens on a rising edge with valid high and stall low.
// The front hashes the key (two registered multiplies) and reduces it modulo
// the capacity in use with a one-bit-per-cycle remainder; it takes no new
// request until it has pushed the last one. A two-entry queue hands
// requests to the back, which reads each probed slot from the registered
// RAM (B_READ, then B_EVAL) and then finishes in B_DONE.
// The result register holds a finished result while the back and front go
// on; a stalled receiver backs up the queue and then the input.
// Synchronous active-low reset clears the slot state (per-slot valid bits
// read as empty, no clearing pass), the stored count, and loads capacity 53
// and entry limit 26. Configuration (cfg_we, cfg_index, cfg_wdata) must be
// written only while the block is idle; the block itself does not enforce it.
module linear_probe_hash_set_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [5:0]         out_slot_index,
  output logic [6:0]         out_stored_count,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata
);
  import lphs_pkg::*;

  localparam int unsigned SLOTS = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] max_r;
  logic [CAP_W-1:0] cap_eff;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  req_t             push_req;
  req_t             pop_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(53);
      max_r <= CAP_W'(26);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY: cap_r <= cfg_wdata;
        REG_MAX:      max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > CAP_W'(SLOTS)) begin
      cap_eff = CAP_W'(SLOTS);
    end
  end

  lphs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_opcode(in_opcode),
    .in_key   (in_key),
    .cap      (cap_eff),
    .push     (push),
    .push_req (push_req),
    .q_full   (q_full)
  );

  lphs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .pop_req  (pop_req),
    .empty    (q_empty)
  );

  lphs_back #(.SLOTS(SLOTS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_req           (pop_req),
    .pop             (pop),
    .cap             (cap_eff),
    .max_entries     (max_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_stored_count(out_stored_count)
  );
endmodule

FILE: rtl/core/lphs_chk.sv
// Port-level checker for the hash set, bound to the top level
`include "assert_macros.svh"
module lphs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_status,
  input logic [5:0]         out_slot_index,
  input logic [6:0]         out_stored_count
);
  import lphs_pkg::*;

  `LPHS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)
  `LPHS_ASSERT(a_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_slot_index))
  `LPHS_ASSERT(a_miss_slot_zero, clk, rst_n,
    out_valid && (out_status == ST_NOTFOUND || out_status == ST_FULL) |-> out_slot_index == 6'd0)
  `LPHS_ASSERT(a_insert_count, clk, rst_n,
    out_valid && (out_status == ST_INSERTED || out_status == ST_PRESENT ||
    out_status == ST_FOUND) |-> out_stored_count != 7'd0)
endmodule

bind linear_probe_hash_set_core lphs_chk u_lphs_chk (.*);

FILE: dv/linear_probe_hash_set_core_tb.sv
// Self-checking testbench for the linear probe hash set core
`timescale 1ns / 100ps

module linear_probe_hash_set_core_tb;
  import lphs_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
  } req_s;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic [6:0] count;
  } rsp_s;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic signed [31:0] in_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [5:0] out_slot_index;
  logic [6:0] out_stored_count;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [6:0] cfg_wdata = '0;

  linear_probe_hash_set_core u_dut (.*);

  // predictor state
  logic [31:0] tbl_key [64];
  mark_t       tbl_mark [64];
  logic [6:0]  n_stored;
  logic [6:0]  cap_reg;
  logic [6:0]  limit_reg;

  req_s pending_reqs[$];
  rsp_s expected_rsps[$];
  logic [31:0] used_keys[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  longint cycle_cnt = 0;
  bit done = 0;

  initial forever #10 clk = ~clk;

  function automatic logic [31:0] key_hash(logic [31:0] h);
    h = ((h >> 16) ^ h) * 32'h045D_9F3B;
    h = ((h >> 16) ^ h) * 32'h045D_9F3B;
    return (h >> 16) ^ h;
  endfunction

  function automatic rsp_s apply_request(req_s r);
    int cap, pos;
    bit got_tomb, got_empty, hit;
    int tomb, emp;
    rsp_s o;
    cap = (cap_reg == 0) ? 1 : (cap_reg > 64 ? 64 : cap_reg);
    o.status = ST_NOTFOUND;
    o.slot = '0;
    got_tomb = 0; got_empty = 0; hit = 0; tomb = 0; emp = 0;
    pos = key_hash(r.key) % cap;
    if (r.op == OP_INSERT || ((r.op == OP_REMOVE || r.op == OP_SEARCH) && n_stored != 0)) begin
      for (int n = 0; n < cap; n++) begin
        if (tbl_mark[pos] == MARK_EMPTY) begin
          got_empty = 1; emp = pos;
          break;
        end else if (tbl_mark[pos] == MARK_USED) begin
          if (tbl_key[pos] == r.key) begin
            hit = 1; o.slot = 6'(pos);
            break;
          end
        end else if (!got_tomb) begin
          got_tomb = 1; tomb = pos;
        end
        pos = (pos + 1 == cap) ? 0 : pos + 1;
      end
    end
    case (r.op)
      OP_INSERT: begin
        if (hit) o.status = ST_PRESENT;
        else if (n_stored >= limit_reg || (!got_tomb && !got_empty)) begin
          o.status = ST_FULL;
          o.slot = '0;
        end else begin
          pos = got_tomb ? tomb : emp;
          tbl_key[pos] = r.key;
          tbl_mark[pos] = MARK_USED;
          n_stored = n_stored + 7'd1;
          o.status = ST_INSERTED;
          o.slot = 6'(pos);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          tbl_mark[o.slot] = MARK_TOMB;
          n_stored = n_stored - 7'd1;
          o.status = ST_REMOVED;
        end else o.slot = '0;
      end
      OP_SEARCH: begin
        if (hit) o.status = ST_FOUND;
        else o.slot = '0;
      end
      default: o.slot = '0;
    endcase
    o.count = n_stored;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) expected_rsps.push_back(apply_request({in_opcode, in_key}));
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          req_s r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_opcode <= r.op;
          in_key <= r.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected transfer status=%0d slot=%0d count=%0d", $time,
                   out_status, out_slot_index, out_stored_count);
          errors++;
        end else begin
          rsp_s e;
          e = expected_rsps.pop_front();
          if (e.status != out_status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
            errors++;
          end
          if (e.slot != out_slot_index) begin
            $display("%0t: slot exp %0d got %0d", $time, e.slot, out_slot_index);
            errors++;
          end
          if (e.count != out_stored_count) begin
            $display("%0t: count exp %0d got %0d", $time, e.count, out_stored_count);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
    if (cycle_cnt > 3_000_000 && !done) begin
      $display("linear_probe_hash_set_core_tb: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) cap_reg = val;
    else limit_reg = val;
  endtask

  function automatic logic [31:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(99) < 60)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    pick_key = $urandom();
    if ($urandom_range(3) == 0) pick_key = $urandom_range(15);
    used_keys.push_back(pick_key);
    if (used_keys.size() > 48) void'(used_keys.pop_front());
  endfunction

  task automatic add_random(int count);
    req_s r;
    int w;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(99);
      r.op = (w < 45) ? OP_INSERT : (w < 72) ? OP_REMOVE : (w < 97) ? OP_SEARCH : OP_NONE;
      r.key = pick_key();
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    logic [6:0] caps[6] = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127, 7'd9};
    logic [6:0] lims[6] = '{7'd1, 7'd64, 7'd40, 7'd0, 7'd127, 7'd5};
    for (int i = 0; i < 64; i++) begin
      tbl_key[i] = '0;
      tbl_mark[i] = MARK_EMPTY;
    end
    n_stored = '0;
    cap_reg = 7'd53;
    limit_reg = 7'd26;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty set, extremes, opcode 3, duplicate insert, tombstones
    pending_reqs.push_back({OP_SEARCH, 32'h0});
    pending_reqs.push_back({OP_REMOVE, 32'h8000_0000});
    pending_reqs.push_back({OP_NONE, 32'hFFFF_FFFF});
    pending_reqs.push_back({OP_INSERT, 32'h8000_0000});
    pending_reqs.push_back({OP_INSERT, 32'h7FFF_FFFF});
    pending_reqs.push_back({OP_INSERT, 32'hFFFF_FFFF});
    pending_reqs.push_back({OP_INSERT, 32'h0});
    pending_reqs.push_back({OP_INSERT, 32'h8000_0000});
    pending_reqs.push_back({OP_SEARCH, 32'h7FFF_FFFF});
    pending_reqs.push_back({OP_REMOVE, 32'hFFFF_FFFF});
    pending_reqs.push_back({OP_SEARCH, 32'hFFFF_FFFF});
    pending_reqs.push_back({OP_INSERT, 32'h5555_AAAA});
    pending_reqs.push_back({OP_NONE, 32'h0});
    wait_drained();

    // tiny table: probe wrap, no free slot
    write_reg(REG_CAPACITY, 7'd2);
    write_reg(REG_MAX, 7'd64);
    for (int k = 1; k <= 5; k++) pending_reqs.push_back({OP_INSERT, 32'(k)});
    pending_reqs.push_back({OP_REMOVE, 32'h2});
    pending_reqs.push_back({OP_INSERT, 32'h9});
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CAPACITY, caps[ph]);
      write_reg(REG_MAX, lims[ph]);
      send_idle = (ph < 2) ? 28 : (ph < 4) ? 61 : 0;
      recv_idle = (ph < 2) ? 61 : (ph < 4) ? 28 : 0;
      if (ph == 2) hold_cycles = 600;
      add_random(320);
      wait_drained();
    end
    done = 1;
    if (errors == 0) $display("linear_probe_hash_set_core_tb: done, clean");
    else $display("linear_probe_hash_set_core_tb: done, errors");
    $finish;
  end

endmodule
